// ===== rtl/core/wwsc_pkg.sv =====
// Shared types, constants and byte helpers for the whole-word substring counter.
`timescale 1ns / 1ps
package wwsc_pkg;

    localparam int MAX_NEEDLE_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int NEEDLE_BYTES  = 16;
    localparam int NEEDLE_BITS   = 8 * NEEDLE_BYTES;
    localparam int NEEDLE_SEL_W  = $clog2(NEEDLE_BYTES);
    localparam int LEN_REG_W     = 5;
    localparam int APB_DATA_W    = 64;
    localparam int PADDR_W       = 6;
    localparam int RESULT_W      = 32;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_0          = 8'h30;
    localparam logic [7:0] CHAR_9          = 8'h39;
    localparam logic [7:0] CHAR_UC_A       = 8'h41;
    localparam logic [7:0] CHAR_UC_Z       = 8'h5A;
    localparam logic [7:0] CHAR_LC_A       = 8'h61;
    localparam logic [7:0] CHAR_LC_Z       = 8'h7A;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    typedef enum logic [2:0] {
        REG_NEEDLE_LO  = 3'd0,
        REG_NEEDLE_HI  = 3'd1,
        REG_NEEDLE_LEN = 3'd2,
        REG_CASE_SENS  = 3'd3,
        REG_WHOLE_WORD = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                any_match;
        logic [RESULT_W-1:0] match_total;
    } t_out_item;

    typedef struct packed {
        logic [NEEDLE_BITS-1:0] needle;
        logic [LEN_REG_W-1:0]   needle_length;
        logic                   case_sensitive;
        logic                   whole_word_only;
    } t_cfg;

    typedef struct packed {
        logic fire;
        logic last;
        logic boundary_new;
        logic boundary_left;
        logic window_hit;
    } t_step;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
        logic [7:0] r;
        r = b;
        if (!exact && b >= CHAR_UC_A && b <= CHAR_UC_Z) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_boundary(input logic [7:0] b);
        logic alnum;
        alnum = (b >= CHAR_0 && b <= CHAR_9) || (b >= CHAR_UC_A && b <= CHAR_UC_Z)
             || (b >= CHAR_LC_A && b <= CHAR_LC_Z);
        return !alnum && (b != CHAR_UNDERSCORE);
    endfunction

endpackage

// ===== rtl/core/whole_word_substring_counter.sv =====
// Whole-word substring counter: streams text bytes, counts non-overlapping needle hits.
// Throughput: one text byte per cycle; input stalls only when a last byte meets a held result.
// Latency: the result is registered and appears the cycle after the last byte is accepted.
// Matching is a shift chain of MAX_NEEDLE byte cells compared in parallel against the needle.
// Reset clears the registers, counters, pending hit and the output valid flag; the output data is not reset.
`timescale 1ns / 1ps
module whole_word_substring_counter
    import wwsc_pkg::*;
#(
    parameter int MAX_NEEDLE  = MAX_NEEDLE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

    t_cfg                  cfg;
    logic                  fire;
    logic [LEN_W-1:0]      eff_len;
    logic [7:0]            win_next [MAX_NEEDLE+1];
    logic [MAX_NEEDLE-1:0] hits;
    t_step                 step;

    wwsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign fire    = i_in_valid & !o_in_stall;
    assign eff_len = (cfg.needle_length > LEN_REG_W'(MAX_NEEDLE)) ? LEN_W'(MAX_NEEDLE)
                   : LEN_W'(cfg.needle_length);

    assign win_next[0] = i_in_data.text_byte;

    generate
        for (genvar g = 0; g < MAX_NEEDLE; g++) begin : g_cell
            wwsc_cell #(
                .MAX_NEEDLE (MAX_NEEDLE),
                .IDX        (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (fire),
                .i_byte   (win_next[g]),
                .i_len    (eff_len),
                .i_needle (cfg.needle),
                .i_exact  (cfg.case_sensitive),
                .o_byte   (win_next[g+1]),
                .o_hit    (hits[g])
            );
        end
    endgenerate

    assign step.fire          = fire;
    assign step.last          = i_in_data.last_byte;
    assign step.boundary_new  = is_boundary(i_in_data.text_byte);
    assign step.boundary_left = is_boundary(win_next[eff_len]);
    assign step.window_hit    = &hits;

    wwsc_ctrl #(
        .MAX_NEEDLE  (MAX_NEEDLE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_len        (eff_len),
        .i_whole_word (cfg.whole_word_only),
        .i_last_in    (i_in_data.last_byte),
        .i_out_stall  (i_out_stall),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== rtl/core/wwsc_regs.sv =====
// APB configuration registers: needle bytes, needle length and match mode.
`timescale 1ns / 1ps
module wwsc_regs
    import wwsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [APB_DATA_W-1:0] r_needle_lo;
    logic [APB_DATA_W-1:0] r_needle_hi;
    logic [LEN_REG_W-1:0]  r_len;
    logic                  r_case_sens;
    logic                  r_whole_word;
    t_reg_idx              reg_idx;
    logic                  wr_en;

    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_lo  <= '0;
            r_needle_hi  <= '0;
            r_len        <= '0;
            r_case_sens  <= 1'b0;
            r_whole_word <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEEDLE_LO:  r_needle_lo  <= pwdata;
                REG_NEEDLE_HI:  r_needle_hi  <= pwdata;
                REG_NEEDLE_LEN: r_len        <= pwdata[LEN_REG_W-1:0];
                REG_CASE_SENS:  r_case_sens  <= pwdata[0];
                REG_WHOLE_WORD: r_whole_word <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEEDLE_LO:  prdata = r_needle_lo;
            REG_NEEDLE_HI:  prdata = r_needle_hi;
            REG_NEEDLE_LEN: prdata = APB_DATA_W'(r_len);
            REG_CASE_SENS:  prdata = APB_DATA_W'(r_case_sens);
            REG_WHOLE_WORD: prdata = APB_DATA_W'(r_whole_word);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.needle          = {r_needle_hi, r_needle_lo};
    assign o_cfg.needle_length   = r_len;
    assign o_cfg.case_sensitive  = r_case_sens;
    assign o_cfg.whole_word_only = r_whole_word;

endmodule

// ===== rtl/core/wwsc_cell.sv =====
// Window cell: holds one text byte, shifts it on, compares the incoming byte.
`timescale 1ns / 1ps
module wwsc_cell
    import wwsc_pkg::*;
#(
    parameter int MAX_NEEDLE = MAX_NEEDLE_DEF,
    parameter int IDX        = 0,
    localparam int LEN_W     = $clog2(MAX_NEEDLE + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [7:0]             i_byte,
    input  logic [LEN_W-1:0]       i_len,
    input  logic [NEEDLE_BITS-1:0] i_needle,
    input  logic                   i_exact,
    output logic [7:0]             o_byte,
    output logic                   o_hit
);

    logic [7:0]              r_byte;
    logic                    active;
    logic [NEEDLE_SEL_W-1:0] sel;
    logic [7:0]              needle_byte;

    assign active      = LEN_W'(IDX) < i_len;
    assign sel         = NEEDLE_SEL_W'(i_len - LEN_W'(IDX) - 1'b1);
    assign needle_byte = i_needle[{sel, 3'b000} +: 8];
    assign o_hit       = !active || (fold_byte(i_byte, i_exact) == fold_byte(needle_byte, i_exact));
    assign o_byte      = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== rtl/core/wwsc_ctrl.sv =====
// Match bookkeeping: holdoff, pending whole-word hit, count and result register.
`timescale 1ns / 1ps
module wwsc_ctrl
    import wwsc_pkg::*;
#(
    parameter int MAX_NEEDLE  = MAX_NEEDLE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int LEN_W      = $clog2(MAX_NEEDLE + 1),
    localparam int SEEN_W     = $clog2(MAX_NEEDLE + 2),
    localparam int HOLD_W     = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step            i_step,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_whole_word,
    input  logic             i_last_in,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data
);

    logic [SEEN_W-1:0]      r_seen, n_seen, seen_next;
    logic [HOLD_W-1:0]      r_hold, n_hold;
    logic                   r_pend, n_pend;
    logic [COUNT_WIDTH-1:0] r_total, n_total, total_step;
    logic [COUNT_WIDTH:0]   sum;
    logic                   inc_a, inc_b;
    logic                   left_ok;
    logic [RESULT_W-1:0]    total_out;
    logic                   r_out_valid;
    t_out_item              r_out;

    assign o_in_stall  = r_out_valid & i_out_stall & i_last_in;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign seen_next = (r_seen < SEEN_W'(MAX_NEEDLE + 1)) ? r_seen + 1'b1 : r_seen;
    assign left_ok   = (seen_next <= SEEN_W'(i_len)) || i_step.boundary_left;

    always_comb begin
        n_seen = r_seen;
        n_hold = r_hold;
        n_pend = r_pend;
        inc_a  = 1'b0;
        inc_b  = 1'b0;
        if (i_step.fire) begin
            n_seen = seen_next;
            inc_a  = r_pend & i_step.boundary_new;
            n_pend = 1'b0;
            if (r_hold != '0) begin
                n_hold = r_hold - 1'b1;
            end else if (i_len != '0 && seen_next >= SEEN_W'(i_len) && i_step.window_hit) begin
                n_hold = HOLD_W'(i_len - 1'b1);
                if (!i_whole_word) begin
                    inc_b = 1'b1;
                end else if (left_ok) begin
                    if (i_step.last) begin
                        inc_b = 1'b1;
                    end else begin
                        n_pend = 1'b1;
                    end
                end
            end
        end
        sum        = {1'b0, r_total} + (COUNT_WIDTH + 1)'(inc_a) + (COUNT_WIDTH + 1)'(inc_b);
        total_step = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        n_total    = total_step;
        if (i_step.fire && i_step.last) begin
            n_seen  = '0;
            n_hold  = '0;
            n_pend  = 1'b0;
            n_total = '0;
        end
    end

    generate
        if (COUNT_WIDTH > RESULT_W) begin : g_wide
            assign total_out = (|total_step[COUNT_WIDTH-1:RESULT_W]) ? '1
                             : total_step[RESULT_W-1:0];
        end else begin : g_narrow
            assign total_out = RESULT_W'(total_step);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_hold      <= '0;
            r_pend      <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_hold  <= n_hold;
            r_pend  <= n_pend;
            r_total <= n_total;
            if (i_step.fire && i_step.last) begin
                r_out_valid       <= 1'b1;
                r_out.any_match   <= (total_step != '0);
                r_out.match_total <= total_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
